@@ hw/rtl/buck_pi_voltage_controller_assert.svh @@
`ifndef BUCK_PI_VOLTAGE_CONTROLLER_ASSERT_SVH
`define BUCK_PI_VOLTAGE_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked at every rising clock edge
`define BPVC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpvc assertion failed");

// next-cycle implication
`define BPVC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpvc assertion failed");

`endif

@@ hw/rtl/bpvc_pkg.sv @@
package bpvc_pkg;

   // configuration port
   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [2:0] {
      CSR_SAMPLE_DIVIDER,
      CSR_SENSE_GAIN,
      CSR_PROP_GAIN,
      CSR_PREV_ERROR_GAIN,
      CSR_RAMP_STEP,
      CSR_RAMP_LIMIT,
      CSR_FINAL_REFERENCE,
      CSR_PWM_PERIOD
   } csr_index_type;

   typedef struct packed {
      logic [7:0]         sample_divider;
      logic [14:0]        sense_gain;
      logic signed [15:0] prop_gain;
      logic signed [15:0] prev_error_gain;
      logic [12:0]        ramp_step;
      logic [14:0]        ramp_limit;
      logic [14:0]        final_reference;
      logic [14:0]        pwm_period;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      sample_divider:  8'd1,
      sense_gain:      15'd20480,
      prop_gain:       16'sd2739,
      prev_error_gain: -16'sd2129,
      ramp_step:       13'd8,
      ramp_limit:      15'd2048,
      final_reference: 15'd4055,
      pwm_period:      15'd28635
   };

   // microcode
   typedef logic [3:0] step_type;

   localparam step_type STEP_WAIT     = 4'd0;
   localparam step_type STEP_RAMP     = 4'd1;
   localparam step_type STEP_VOLT     = 4'd2;
   localparam step_type STEP_ERR      = 4'd3;
   localparam step_type STEP_MUL_PROP = 4'd4;
   localparam step_type STEP_SUM      = 4'd5;
   localparam step_type STEP_ACCUM    = 4'd6;
   localparam step_type STEP_MUL_DUTY = 4'd7;
   localparam step_type STEP_DUTY     = 4'd8;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_RAMP,
      OP_VOLT,
      OP_ERR,
      OP_SUM,
      OP_ACCUM,
      OP_DUTY
   } dp_op_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_VOLT,
      MUL_PREV,
      MUL_PROP,
      MUL_DUTY
   } mul_sel_type;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_UPDATE,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      logic        take_in;
      cond_type    cond;
      step_type    target;
      mul_sel_type mul_sel;
      dp_op_type   op;
   } ucode_word_type;

   typedef struct packed {
      logic update;
      logic out_free;
   } seq_status_type;

   // saturate a 17-bit signed sum to 16 bits
   function automatic logic signed [15:0] sat17(input logic signed [16:0] s);
      if (s[16] != s[15]) begin
         return s[16] ? 16'sh8000 : 16'sh7fff;
      end
      return s[15:0];
   endfunction

   function automatic ucode_word_type mk_word(input logic take_in, input cond_type cond,
                                             input step_type target,
                                             input mul_sel_type mul_sel,
                                             input dp_op_type op);
      ucode_word_type w;
      w.take_in = take_in;
      w.cond    = cond;
      w.target  = target;
      w.mul_sel = mul_sel;
      w.op      = op;
      return w;
   endfunction

   // control program, one word per step
   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type w;
      unique case (step)
         STEP_WAIT:     w = mk_word(1'b1, COND_UPDATE, STEP_RAMP, MUL_NONE, OP_NONE);
         STEP_RAMP:     w = mk_word(1'b0, COND_ALWAYS, STEP_VOLT, MUL_VOLT, OP_RAMP);
         STEP_VOLT:     w = mk_word(1'b0, COND_ALWAYS, STEP_ERR, MUL_PREV, OP_VOLT);
         STEP_ERR:      w = mk_word(1'b0, COND_ALWAYS, STEP_MUL_PROP, MUL_NONE, OP_ERR);
         STEP_MUL_PROP: w = mk_word(1'b0, COND_ALWAYS, STEP_SUM, MUL_PROP, OP_NONE);
         STEP_SUM:      w = mk_word(1'b0, COND_ALWAYS, STEP_ACCUM, MUL_NONE, OP_SUM);
         STEP_ACCUM:    w = mk_word(1'b0, COND_ALWAYS, STEP_MUL_DUTY, MUL_NONE, OP_ACCUM);
         STEP_MUL_DUTY: w = mk_word(1'b0, COND_ALWAYS, STEP_DUTY, MUL_DUTY, OP_NONE);
         STEP_DUTY:     w = mk_word(1'b0, COND_OUT_FREE, STEP_WAIT, MUL_NONE, OP_DUTY);
         default:       w = mk_word(1'b0, COND_ALWAYS, STEP_WAIT, MUL_NONE, OP_NONE);
      endcase
      return w;
   endfunction

endpackage

@@ hw/rtl/bpvc_if.sv @@
interface bpvc_req_if #(
   parameter int ADC_BITS = 10
);
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface bpvc_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        duty_count;
   logic [14:0]        control_action;
   logic signed [15:0] reference_now;
   logic               ramp_done;

   modport source (output valid, output duty_count, output control_action,
                   output reference_now, output ramp_done, input ready);
   modport sink   (input valid, input duty_count, input control_action,
                   input reference_now, input ramp_done, output ready);
endinterface

@@ hw/rtl/bpvc_csr.sv @@
module bpvc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  bpvc_pkg::csr_index_type             csr_index,
   input  logic [bpvc_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output bpvc_pkg::cfg_type                   cfg
);
   import bpvc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLE_DIVIDER:  cfg_in.sample_divider  = csr_wdata[7:0];
            CSR_SENSE_GAIN:      cfg_in.sense_gain      = csr_wdata[14:0];
            CSR_PROP_GAIN:       cfg_in.prop_gain       = $signed(csr_wdata[15:0]);
            CSR_PREV_ERROR_GAIN: cfg_in.prev_error_gain = $signed(csr_wdata[15:0]);
            CSR_RAMP_STEP:       cfg_in.ramp_step       = csr_wdata[12:0];
            CSR_RAMP_LIMIT:      cfg_in.ramp_limit      = csr_wdata[14:0];
            CSR_FINAL_REFERENCE: cfg_in.final_reference = csr_wdata[14:0];
            CSR_PWM_PERIOD:      cfg_in.pwm_period      = csr_wdata[14:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/bpvc_sequencer.sv @@
module bpvc_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  bpvc_pkg::seq_status_type status,
   output bpvc_pkg::ucode_word_type ctrl
);
   import bpvc_pkg::*;

   step_type       pc_ff;
   step_type       pc_in;
   ucode_word_type word;
   logic           jump;

   // fetch the control word of the current step
   assign word = ucode_rom(pc_ff);

   // jump condition
   always_comb begin
      unique case (word.cond)
         COND_ALWAYS:   jump = 1'b1;
         COND_UPDATE:   jump = status.update;
         COND_OUT_FREE: jump = status.out_free;
         default:       jump = 1'b1;
      endcase
   end

   // step counter: go to target or hold
   assign pc_in = jump ? word.target : pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl = word;

endmodule

@@ hw/rtl/bpvc_datapath.sv @@
module bpvc_datapath #(
   parameter int ADC_BITS    = 10,
   parameter int Q_FRAC_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bpvc_pkg::cfg_type         cfg,
   input  bpvc_pkg::ucode_word_type  ctrl,
   output bpvc_pkg::seq_status_type  status,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [ADC_BITS-1:0]       req_adc_sample,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [15:0]               rsp_duty_count,
   output logic [14:0]               rsp_control_action,
   output logic signed [15:0]        rsp_reference_now,
   output logic                      rsp_ramp_done
);
   import bpvc_pkg::*;

   // multiplier operand and product widths
   localparam int OPW = (ADC_BITS + 1 > 17) ? ADC_BITS + 1 : 17;
   localparam int PW  = 2 * OPW;

   // product to Q format: floor shift, then saturate to 16 bits
   function automatic logic signed [15:0] qsat(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      s = p >>> Q_FRAC_BITS;
      if ((&s[PW-1:15]) || !(|s[PW-1:15])) begin
         return s[15:0];
      end
      return s[PW-1] ? 16'sh8000 : 16'sh7fff;
   endfunction

   logic [7:0]           tick_ff, tick_in;
   logic [ADC_BITS-1:0]  adc_ff;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [15:0]   volt_ff, volt_in;
   logic signed [15:0]   ref_ff, ref_in;
   logic                 flag_ff, flag_in;
   logic signed [15:0]   err_ff, err_in;
   logic signed [15:0]   term_ff, term_in;
   logic signed [15:0]   acc_ff, acc_in;
   logic signed [15:0]   last_error_ff, last_error_in;
   logic signed [15:0]   last_action_ff, last_action_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          duty_ff, duty_in;
   logic [14:0]          action_ff, action_in;
   logic signed [15:0]   ref_out_ff, ref_out_in;
   logic                 done_out_ff, done_out_in;

   logic                  accept;
   logic [7:0]            tick_inc;
   logic                  match;
   logic                  out_free;
   logic                  write_out;
   logic signed [OPW-1:0] mul_a, mul_b;
   logic [15:0]           period_p1;
   logic signed [15:0]    prod_q;
   logic [14:0]           act;
   logic                  duty_over;
   logic [15:0]           duty_val;

   // input transaction and sample divider
   assign req_ready = ctrl.take_in;
   assign accept    = req_valid && ctrl.take_in;
   assign tick_inc  = tick_ff + 8'd1;
   assign match     = (tick_inc == cfg.sample_divider);

   // output register handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign write_out = (ctrl.op == OP_DUTY) && out_free;

   assign status.update   = accept && match;
   assign status.out_free = out_free;

   // shared multiplier operand select
   assign period_p1 = {1'b0, cfg.pwm_period} + 16'd1;

   always_comb begin
      unique case (ctrl.mul_sel)
         MUL_VOLT: begin
            mul_a = $signed({{(OPW-ADC_BITS){1'b0}}, adc_ff});
            mul_b = $signed({{(OPW-15){1'b0}}, cfg.sense_gain});
         end
         MUL_PREV: begin
            mul_a = $signed({{(OPW-16){last_error_ff[15]}}, last_error_ff});
            mul_b = $signed({{(OPW-16){cfg.prev_error_gain[15]}}, cfg.prev_error_gain});
         end
         MUL_PROP: begin
            mul_a = $signed({{(OPW-16){err_ff[15]}}, err_ff});
            mul_b = $signed({{(OPW-16){cfg.prop_gain[15]}}, cfg.prop_gain});
         end
         MUL_DUTY: begin
            mul_a = $signed({{(OPW-15){1'b0}}, act});
            mul_b = $signed({{(OPW-16){1'b0}}, period_p1});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = (ctrl.mul_sel != MUL_NONE) ? (mul_a * mul_b) : prod_ff;

   // product views
   assign prod_q    = qsat(prod_ff);
   assign act       = last_action_ff[15] ? 15'd0 : last_action_ff[14:0];
   assign duty_over = |prod_ff[PW-1:Q_FRAC_BITS+15];
   assign duty_val  = duty_over ? 16'hffff
                                : {prod_ff[Q_FRAC_BITS+14:Q_FRAC_BITS], 1'b0};

   // datapath operations
   always_comb begin
      volt_in        = volt_ff;
      ref_in         = ref_ff;
      flag_in        = flag_ff;
      err_in         = err_ff;
      term_in        = term_ff;
      acc_in         = acc_ff;
      last_error_in  = last_error_ff;
      last_action_in = last_action_ff;
      unique case (ctrl.op)
         OP_RAMP: begin
            if (ref_ff < $signed({1'b0, cfg.ramp_limit})) begin
               ref_in = sat17($signed({ref_ff[15], ref_ff})
                              + $signed({4'b0, cfg.ramp_step}));
            end else begin
               ref_in  = $signed({1'b0, cfg.final_reference});
               flag_in = 1'b1;
            end
         end
         OP_VOLT: begin
            volt_in = prod_q;
         end
         OP_ERR: begin
            err_in  = sat17($signed({ref_ff[15], ref_ff})
                            - $signed({volt_ff[15], volt_ff}));
            term_in = prod_q;
         end
         OP_SUM: begin
            acc_in = sat17($signed({term_ff[15], term_ff})
                           + $signed({prod_q[15], prod_q}));
         end
         OP_ACCUM: begin
            last_action_in = sat17($signed({acc_ff[15], acc_ff})
                                   + $signed({last_action_ff[15], last_action_ff}));
            last_error_in  = err_ff;
         end
         default: begin
         end
      endcase
   end

   // tick counter
   always_comb begin
      tick_in = tick_ff;
      if (accept) begin
         tick_in = match ? 8'd0 : tick_inc;
      end
   end

   // result register
   always_comb begin
      duty_in     = duty_ff;
      action_in   = action_ff;
      ref_out_in  = ref_out_ff;
      done_out_in = done_out_ff;
      if (write_out) begin
         rsp_valid_in = 1'b1;
         duty_in      = duty_val;
         action_in    = act;
         ref_out_in   = ref_ff;
         done_out_in  = flag_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff        <= '0;
         ref_ff         <= '0;
         flag_ff        <= 1'b0;
         last_error_ff  <= '0;
         last_action_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         tick_ff        <= tick_in;
         ref_ff         <= ref_in;
         flag_ff        <= flag_in;
         last_error_ff  <= last_error_in;
         last_action_ff <= last_action_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         adc_ff <= req_adc_sample;
      end
      prod_ff     <= prod_in;
      volt_ff     <= volt_in;
      err_ff      <= err_in;
      term_ff     <= term_in;
      acc_ff      <= acc_in;
      duty_ff     <= duty_in;
      action_ff   <= action_in;
      ref_out_ff  <= ref_out_in;
      done_out_ff <= done_out_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_duty_count     = duty_ff;
   assign rsp_control_action = action_ff;
   assign rsp_reference_now  = ref_out_ff;
   assign rsp_ramp_done      = done_out_ff;

endmodule

@@ hw/rtl/buck_pi_voltage_controller.sv @@
// Buck converter output-voltage controller, incremental PI in Q12.
// req_chan carries one ADC sample per transaction (valid/ready). Every
// sample_divider-th sample is a control update and produces exactly one
// transaction on rsp_chan: duty count, clamped action, reference used and
// the ramp-done flag. Other samples produce no result.
// csr_* is a write-only register port (index 0..7 as in the register map);
// it is to be written only while the block is idle; the block does not enforce this.
// A sample that is not an update is taken while the program waits at its
// first step. An update sample is taken, then runs a nine-step microprogram
// through one shared 17x17 multiplier; its result becomes valid as the program
// returns to its wait step, and the next sample can be taken in the same cycle.
// No new sample is taken while the microprogram runs.
// The result sits in an output register; while the receiver stalls, the
// program holds at its last step and req_chan.ready stays low until the
// output register frees.
// Reset (synchronous, active high) loads the register defaults and clears
// the divider count, reference, error and action history and ramp flag.
module buck_pi_voltage_controller #(
   parameter int ADC_BITS    = 10,
   parameter int Q_FRAC_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   bpvc_req_if.sink                           req_chan,
   bpvc_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  bpvc_pkg::csr_index_type            csr_index,
   input  logic [bpvc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import bpvc_pkg::*;

   cfg_type        cfg;
   ucode_word_type ctrl;
   seq_status_type status;

   // configuration registers
   bpvc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // program counter and control store
   bpvc_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // arithmetic and state
   bpvc_datapath #(
      .ADC_BITS    (ADC_BITS),
      .Q_FRAC_BITS (Q_FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .ctrl               (ctrl),
      .status             (status),
      .req_valid          (req_chan.valid),
      .req_ready          (req_chan.ready),
      .req_adc_sample     (req_chan.adc_sample),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_duty_count     (rsp_chan.duty_count),
      .rsp_control_action (rsp_chan.control_action),
      .rsp_reference_now  (rsp_chan.reference_now),
      .rsp_ramp_done      (rsp_chan.ramp_done)
   );

endmodule

@@ hw/rtl/bpvc_checker.sv @@
`include "buck_pi_voltage_controller_assert.svh"

module bpvc_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_ramp_done
);

   // a waiting result stays offered until taken
   `BPVC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // reset empties the output register
   `BPVC_ASSERT_NXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid)

   // a new result shows the sequencer back at its input step
   `BPVC_ASSERT_IMP(a_rsp_rise_ready, clock, reset, rsp_valid && !$past(rsp_valid), req_ready)

   // the ramp flag, once reported, never drops
   `BPVC_ASSERT_IMP(a_ramp_done_sticky, clock, reset, $past(rsp_ramp_done) && !$past(reset), rsp_ramp_done)

endmodule

bind buck_pi_voltage_controller bpvc_checker u_chk (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_ramp_done (rsp_chan.ramp_done)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import bpvc_pkg::*;

   localparam int ADC_BITS      = 10;
   localparam int Q_FRAC_BITS   = 12;
   localparam int CLOCK_PERIOD  = 8;
   localparam int IDLE_PERCENT  = 23;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 150;
   localparam int RANDOM_ITEMS  = 220;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic [15:0]        duty_count;
      logic [14:0]        control_action;
      logic signed [15:0] reference_now;
      logic               ramp_done;
   } duty_update_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_we;
   csr_index_type            csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   bpvc_req_if #(.ADC_BITS(ADC_BITS)) req_chan_if ();
   bpvc_rsp_if                        rsp_chan_if ();

   // controller model state, cleared like the block at reset
   cfg_type            active_cfg   = CFG_RESET;
   logic [7:0]         tick_count   = '0;
   logic signed [15:0] pi_reference = '0;
   logic signed [15:0] prev_error   = '0;
   logic signed [15:0] prev_action  = '0;
   logic               ramp_latched = 1'b0;

   duty_update_type expected_updates[$];
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   int              idle_pct       = IDLE_PERCENT;
   logic            hold_request   = 1'b0;
   int              hold_left      = 0;

   buck_pi_voltage_controller #(
      .ADC_BITS    (ADC_BITS),
      .Q_FRAC_BITS (Q_FRAC_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan_if),
      .rsp_chan  (rsp_chan_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // saturate to the signed q12 range
   function automatic logic signed [15:0] clip16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // q12 product, floor shift then saturate
   function automatic logic signed [15:0] q12_mul(input longint a, input longint b);
      return clip16((a * b) >>> Q_FRAC_BITS);
   endfunction

   // advance the divider and, on a control update, queue the expected pwm update
   function automatic void predict_control_update(input logic [ADC_BITS-1:0] adc);
      longint          volt;
      longint          err;
      longint          acc;
      longint          act;
      longint          duty;
      duty_update_type upd;
      tick_count = tick_count + 8'd1;
      if (tick_count != active_cfg.sample_divider) return;
      tick_count = '0;

      volt = longint'(q12_mul(longint'(adc), longint'(active_cfg.sense_gain)));

      // reference ramp, then jump to the final level
      if (longint'(pi_reference) < longint'(active_cfg.ramp_limit)) begin
         pi_reference = clip16(longint'(pi_reference) + longint'(active_cfg.ramp_step));
      end else begin
         pi_reference = 16'(active_cfg.final_reference);
         ramp_latched = 1'b1;
      end

      // incremental pi
      err = longint'(clip16(longint'(pi_reference) - volt));
      acc = longint'(clip16(longint'(q12_mul(err, longint'($signed(active_cfg.prop_gain))))
                   + longint'(q12_mul(longint'(prev_error),
                                      longint'($signed(active_cfg.prev_error_gain))))));
      acc = longint'(clip16(acc + longint'(prev_action)));
      prev_error  = err[15:0];
      prev_action = acc[15:0];

      act  = (acc < 0) ? 0 : acc;
      duty = ((act * (longint'(active_cfg.pwm_period) + 1)) >>> Q_FRAC_BITS) <<< 1;
      if (duty > 65535) duty = 65535;

      upd.duty_count     = duty[15:0];
      upd.control_action = act[14:0];
      upd.reference_now  = pi_reference;
      upd.ramp_done      = ramp_latched;
      expected_updates.push_back(upd);
   endfunction

   function automatic void check_field(input string field, input longint want,
                                       input longint seen);
      if (want != seen) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, seen);
         mismatch_count++;
      end
   endfunction

   function automatic int pick_in_range(input int lo, input int hi);
      case ($urandom_range(7))
         0: return lo;
         1: return hi;
         default: return lo + int'($urandom_range(hi - lo));
      endcase
   endfunction

   function automatic logic [ADC_BITS-1:0] random_sample();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return ADC_BITS'($urandom_range((1 << ADC_BITS) - 1));
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c = CFG_RESET;
      c.sample_divider = ($urandom_range(9) == 0) ? 8'($urandom_range(4, 12))
                                                  : 8'($urandom_range(1, 3));
      c.pwm_period = 15'(pick_in_range(0, 32767));
      // half the phases keep the gains and ramp settings at their reset values
      if ($urandom_range(1) == 1) begin
         c.sense_gain      = 15'(pick_in_range(0, 32767));
         c.prop_gain       = 16'(pick_in_range(-32768, 32767));
         c.prev_error_gain = 16'(pick_in_range(-32768, 32767));
         c.ramp_step       = 13'(pick_in_range(0, 4096));
         c.ramp_limit      = 15'(pick_in_range(0, 32767));
         c.final_reference = 15'(pick_in_range(0, 32767));
      end
      return c;
   endfunction

   // one adc sample transaction; returns at the accepting edge with valid still high
   task automatic send_sample(input logic [ADC_BITS-1:0] adc);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_chan_if.valid      <= 1'b0;
         req_chan_if.adc_sample <= ADC_BITS'($urandom);
         @(posedge clock);
      end
      req_chan_if.valid      <= 1'b1;
      req_chan_if.adc_sample <= adc;
      @(posedge clock);
      while (!req_chan_if.ready) @(posedge clock);
      predict_control_update(adc);
   endtask

   // drain outstanding updates and let a possible non-update sample finish
   task automatic wait_idle();
      req_chan_if.valid <= 1'b0;
      while (expected_updates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type c);
      wait_idle();
      write_reg(CSR_SAMPLE_DIVIDER, CSR_DATA_BITS'(c.sample_divider));
      write_reg(CSR_SENSE_GAIN, CSR_DATA_BITS'(c.sense_gain));
      write_reg(CSR_PROP_GAIN, c.prop_gain);
      write_reg(CSR_PREV_ERROR_GAIN, c.prev_error_gain);
      write_reg(CSR_RAMP_STEP, CSR_DATA_BITS'(c.ramp_step));
      write_reg(CSR_RAMP_LIMIT, CSR_DATA_BITS'(c.ramp_limit));
      write_reg(CSR_FINAL_REFERENCE, CSR_DATA_BITS'(c.final_reference));
      write_reg(CSR_PWM_PERIOD, CSR_DATA_BITS'(c.pwm_period));
      csr_we     <= 1'b0;
      active_cfg  = c;
   endtask

   // nominal settings, field extremes and alternating bit patterns
   task automatic test_default_settings();
      apply_settings(CFG_RESET);
      send_sample(10'd0);
      send_sample(10'd1023);
      send_sample(10'h155);
      send_sample(10'h2aa);
      send_sample(10'd800);
      send_sample(10'd811);
   endtask

   // products and sums pinned at both rails, duty saturation
   task automatic test_q12_saturation();
      cfg_type c;
      c                 = CFG_RESET;
      c.sense_gain      = 15'h7fff;
      c.prop_gain       = 16'sh8000;
      c.prev_error_gain = 16'sh7fff;
      c.pwm_period      = 15'h7fff;
      apply_settings(c);
      send_sample(10'd1023);
      send_sample(10'd1023);
      send_sample(10'd0);
      c.sense_gain      = '0;
      c.prop_gain       = 16'sh7fff;
      c.prev_error_gain = 16'sh8000;
      c.ramp_limit      = '0;
      c.final_reference = 15'h7fff;
      apply_settings(c);
      send_sample(10'd512);
      send_sample(10'd0);
      send_sample(10'd1023);
   endtask

   // final level below the limit restarts the ramp; ramp add saturates; zero step
   task automatic test_ramp_resume();
      cfg_type c;
      c                 = CFG_RESET;
      c.ramp_step       = 13'd4096;
      c.ramp_limit      = 15'h7fff;
      c.final_reference = '0;
      c.pwm_period      = '0;
      apply_settings(c);
      repeat (9) send_sample(random_sample());
      c.ramp_step       = '0;
      c.final_reference = 15'd30000;
      apply_settings(c);
      repeat (2) send_sample(random_sample());
   endtask

   // divider at its top, then zero below the running count so the count wraps
   task automatic test_divider_wrap();
      cfg_type c;
      c                = CFG_RESET;
      c.sample_divider = 8'd255;
      apply_settings(c);
      repeat (250) send_sample(random_sample());
      c.sample_divider = '0;
      apply_settings(c);
      repeat (6) send_sample(random_sample());
   endtask

   // long receiver hold while samples keep coming, so the input backs up
   task automatic test_output_stall();
      apply_settings(CFG_RESET);
      idle_pct     = 0;
      hold_request <= 1'b1;
      send_sample(random_sample());
      hold_request <= 1'b0;
      repeat (39) send_sample(random_sample());
      idle_pct = IDLE_PERCENT;
   endtask

   // random settings per phase, random samples within each phase
   task automatic test_random_traffic();
      int sent;
      int phase;
      int len;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         apply_settings(random_settings());
         // one phase runs with no idling on either side
         idle_pct = (phase == 2) ? 0 : IDLE_PERCENT;
         len      = (phase == 2) ? 120 : $urandom_range(20, 60);
         repeat (len) send_sample(random_sample());
         sent  += len;
         phase++;
      end
      idle_pct = IDLE_PERCENT;
   endtask

   // receiver ready, with random stalls and an optional long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan_if.ready <= 1'b0;
         hold_left         <= 0;
      end else if (hold_left != 0) begin
         rsp_chan_if.ready <= 1'b0;
         hold_left         <= hold_left - 1;
      end else if (hold_request) begin
         rsp_chan_if.ready <= 1'b0;
         hold_left         <= HOLD_CYCLES;
      end else begin
         rsp_chan_if.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      duty_update_type want;
      if (!reset && rsp_chan_if.valid && rsp_chan_if.ready) begin
         if (expected_updates.size() == 0) begin
            $display("%0t: unexpected result, expected none actual duty %0d action %0d",
                     $time, rsp_chan_if.duty_count, rsp_chan_if.control_action);
            mismatch_count++;
         end else begin
            want = expected_updates.pop_front();
            check_field("duty_count", want.duty_count, rsp_chan_if.duty_count);
            check_field("control_action", want.control_action, rsp_chan_if.control_action);
            check_field("reference_now", want.reference_now, rsp_chan_if.reference_now);
            check_field("ramp_done", want.ramp_done, rsp_chan_if.ramp_done);
         end
      end
   end

   // cycle limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset                  <= 1'b1;
      csr_we                 <= 1'b0;
      csr_index              <= CSR_SAMPLE_DIVIDER;
      csr_wdata              <= '0;
      req_chan_if.valid      <= 1'b0;
      req_chan_if.adc_sample <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_default_settings();
      test_q12_saturation();
      test_ramp_resume();
      test_divider_wrap();
      test_output_stall();
      test_random_traffic();

      wait_idle();
      if (mismatch_count == 0 && expected_updates.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
